### rtl/argb_channel_blend_multiply_macros.svh
// ----------------------------------------------------------------------------
// ARGB channel blend/multiply assertion macros
// Shared assertion forms, clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef ARGB_CHANNEL_BLEND_MULTIPLY_MACROS_SVH
`define ARGB_CHANNEL_BLEND_MULTIPLY_MACROS_SVH

// Same-cycle implication: when ante holds, cons holds too
`define ACBM_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Delayed implication: when ante holds, cons is checked on a later clock
`define ACBM_ASSERT_LAT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) \
        (ante) |-> ##3 (cons)) else $error(msg);

`endif

### rtl/acbm_pkg.sv
// ----------------------------------------------------------------------------
// ARGB channel blend/multiply package
// Scale format constants and the per-channel operation type.
// ----------------------------------------------------------------------------
package acbm_pkg;

    // Fractional bits of the blend scale; ONE_VAL stands for 1.0
    localparam int unsigned SCALE_FRAC_BITS = 8;
    localparam int unsigned ONE_VAL         = 1 << SCALE_FRAC_BITS;

    // Field widths
    localparam int unsigned CHAN_W  = 8;
    localparam int unsigned COLOR_W = 32;
    localparam int unsigned NUM_CH  = COLOR_W / CHAN_W;
    localparam int unsigned SCALE_W = 9;

    // Saturated weight width (holds 0..ONE_VAL) and compare width
    localparam int unsigned WT_W  = SCALE_FRAC_BITS + 1;
    localparam int unsigned CMP_W = (WT_W > SCALE_W) ? WT_W : SCALE_W;

    // Product widths: a*(ONE-s) and y*s, where y = b<<8 or a*b
    localparam int unsigned PX_W  = CHAN_W + WT_W;
    localparam int unsigned Y_W   = 2 * CHAN_W;
    localparam int unsigned PY_W  = Y_W + WT_W;
    localparam int unsigned SUM_W = PY_W;
    localparam int unsigned RES_LSB = CHAN_W + SCALE_FRAC_BITS;

    // Operation applied to every channel of one item
    typedef struct packed {
        logic               blend;
        logic [SCALE_W-1:0] scale;
    } chan_op_t;

endpackage

### rtl/acbm_chan.sv
// ----------------------------------------------------------------------------
// ARGB channel datapath
// Three-stage pipeline for one 8-bit channel: weights, products, sum/shift.
// ----------------------------------------------------------------------------
module acbm_chan (
    input  logic                          clk,
    input  acbm_pkg::chan_op_t            op,
    input  logic [acbm_pkg::CHAN_W-1:0]   a,
    input  logic [acbm_pkg::CHAN_W-1:0]   b,
    output logic [acbm_pkg::CHAN_W-1:0]   chan_out
);
    import acbm_pkg::*;

    logic [CMP_W-1:0]  scale_ext;
    logic [WT_W-1:0]   s_sat;

    logic [CHAN_W-1:0] a_reg,  a_next;
    logic [Y_W-1:0]    y_reg,  y_next;
    logic [WT_W-1:0]   w0_reg, w0_next;
    logic [WT_W-1:0]   w1_reg, w1_next;

    logic [PX_W-1:0]   px_reg, px_next;
    logic [PY_W-1:0]   py_reg, py_next;

    logic [SUM_W-1:0]  sum;
    logic [CHAN_W-1:0] res_reg, res_next;

    // Stage 1: saturate the scale, form the target term
    always_comb
    begin
        scale_ext = CMP_W'(op.scale);
        if (scale_ext > CMP_W'(ONE_VAL))
        begin
            s_sat = WT_W'(ONE_VAL);
        end
        else
        begin
            s_sat = scale_ext[WT_W-1:0];
        end
        a_next  = a;
        w1_next = s_sat;
        w0_next = WT_W'(ONE_VAL) - s_sat;
        // Blend target is b scaled by 256, multiply target is a*b
        if (op.blend)
        begin
            y_next = {b, CHAN_W'(0)};
        end
        else
        begin
            y_next = Y_W'(a) * Y_W'(b);
        end
    end

    // Stage 2: weight both end points
    always_comb
    begin
        px_next = PX_W'(a_reg) * PX_W'(w0_reg);
        py_next = PY_W'(y_reg) * PY_W'(w1_reg);
    end

    // Stage 3: sum and take the exact floor
    always_comb
    begin
        sum      = {px_reg, CHAN_W'(0)} + py_reg;
        res_next = sum[RES_LSB +: CHAN_W];
    end

    // Advance the payload every cycle; valid bits live in the top level
    always_ff @(posedge clk)
    begin
        a_reg   <= a_next;
        y_reg   <= y_next;
        w0_reg  <= w0_next;
        w1_reg  <= w1_next;
        px_reg  <= px_next;
        py_reg  <= py_next;
        res_reg <= res_next;
    end

    assign chan_out = res_reg;

endmodule

### rtl/argb_channel_blend_multiply.sv
// ----------------------------------------------------------------------------
// ARGB channel blend/multiply
// Blends or modulates two packed ARGB colors channel by channel.
//
//   Channel  | Handshake     | Fields
//   ---------+---------------+-------------------------------------------
//   command  | start / busy  | cmd, color_a, color_b, mix_scale
//   result   | done (strobe) | color_out
//
// One item is taken every cycle; busy stays low.
// Each accepted item passes in order through the weight, product and sum
// stages of each channel pipeline.
// Reset (rst_n, asynchronous) clears only the valid bits.
// The result is shown for one cycle with done high and cannot be held off.
// ----------------------------------------------------------------------------
module argb_channel_blend_multiply (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    output logic                           busy,
    input  logic                           cmd,
    input  logic [acbm_pkg::COLOR_W-1:0]   color_a,
    input  logic [acbm_pkg::COLOR_W-1:0]   color_b,
    input  logic [acbm_pkg::SCALE_W-1:0]   mix_scale,
    output logic                           done,
    output logic [acbm_pkg::COLOR_W-1:0]   color_out
);
    import acbm_pkg::*;

    chan_op_t op;
    logic     accept;
    logic     v1_reg, v1_next;
    logic     v2_reg, v2_next;
    logic     v3_reg, v3_next;

    // Pipeline never stalls, so the command side is always open
    assign busy   = 1'b0;
    assign accept = start & ~busy;

    assign op.blend = cmd;
    assign op.scale = mix_scale;

    // Channel pipelines, one per byte lane
    for (genvar ch = 0; ch < NUM_CH; ch++)
    begin : g_chan
        acbm_chan u_chan (
            .clk      (clk),
            .op       (op),
            .a        (color_a[ch*CHAN_W +: CHAN_W]),
            .b        (color_b[ch*CHAN_W +: CHAN_W]),
            .chan_out (color_out[ch*CHAN_W +: CHAN_W])
        );
    end

    // Advance the valid bits alongside the payload
    always_comb
    begin
        v1_next = accept;
        v2_next = v1_reg;
        v3_next = v2_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= v1_next;
            v2_reg <= v2_next;
            v3_reg <= v3_next;
        end
    end

    assign done = v3_reg;

endmodule

### rtl/acbm_checker.sv
// ----------------------------------------------------------------------------
// ARGB channel blend/multiply checker
// Port-level checks on latency and on result values, bound to the top level.
// ----------------------------------------------------------------------------
`include "argb_channel_blend_multiply_macros.svh"

module acbm_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic                           cmd,
    input  logic [acbm_pkg::COLOR_W-1:0]   color_a,
    input  logic [acbm_pkg::COLOR_W-1:0]   color_b,
    input  logic [acbm_pkg::SCALE_W-1:0]   mix_scale,
    input  logic                           done,
    input  logic [acbm_pkg::COLOR_W-1:0]   color_out
);
    // Every accepted item gives one result with done high
    `ACBM_ASSERT_LAT(a_item_done, start && !busy, done, "accepted item produced no result")

    // No result without a matching accepted item
    `ACBM_ASSERT_LAT(a_no_spurious, !(start && !busy), !done, "result without accepted item")

    // Zero scale passes the first color through in both modes
    `ACBM_ASSERT_IMP(a_zero_scale,
        done && $past(mix_scale, 3) == 0,
        color_out == $past(color_a, 3),
        "zero scale did not return color_a")

    // Blending a color with itself returns that color
    `ACBM_ASSERT_IMP(a_blend_same,
        done && $past(cmd, 3) && $past(color_a, 3) == $past(color_b, 3),
        color_out == $past(color_a, 3),
        "blend of equal colors changed value")

endmodule

bind argb_channel_blend_multiply acbm_checker u_acbm_checker (.*);
